// ----- src/sdm_pkg.sv -----
package sdm_pkg;

    localparam int SDM_MAX_N = 64;

    // item kinds
    localparam logic [2:0] KIND_SET   = 3'd0;
    localparam logic [2:0] KIND_ADD   = 3'd1;
    localparam logic [2:0] KIND_SCALE = 3'd2;
    localparam logic [2:0] KIND_LOAD  = 3'd3;
    localparam logic [2:0] KIND_MUL   = 3'd4;

    // result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_OFF_DIAG = 2'd1;
    localparam logic [1:0] STAT_RANGE    = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_DIAG = 2'd0;
    localparam logic [1:0] CFG_SYM  = 2'd1;
    localparam logic [1:0] CFG_SIZE = 2'd2;

    typedef struct packed {
        logic [2:0]         kind;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [31:0] operand;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [5:0]         row_index;
        logic signed [31:0] product_value;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic vld;
        logic clr;
    } mac_ctl_t;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_SET_A,
        ST_SET_B,
        ST_ADD_RD_A,
        ST_ADD_WR_A,
        ST_ADD_RD_B,
        ST_ADD_WR_B,
        ST_VEC_WR,
        ST_SCALE,
        ST_SCALE_DRAIN,
        ST_MUL_INIT,
        ST_MUL_ISSUE,
        ST_MUL_DRAIN,
        ST_MUL_EMIT,
        ST_ACK
    } state_t;

    // floor shift right by 16, then clamp to 32 bits
    function automatic logic signed [31:0] q_shift_sat(input logic signed [63:0] v);
        logic signed [63:0] s;
        begin
            s = v >>> 16;
            if (s > 64'sd2147483647)
                q_shift_sat = 32'sh7fffffff;
            else if (s < -64'sd2147483648)
                q_shift_sat = 32'sh80000000;
            else
                q_shift_sat = s[31:0];
        end
    endfunction

    // 33-bit exact sum clamped to 32 bits
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] sum;
        begin
            sum = {a[31], a} + {b[31], b};
            if (sum[32] != sum[31])
                sat_add = sum[32] ? 32'sh80000000 : 32'sh7fffffff;
            else
                sat_add = sum[31:0];
        end
    endfunction

endpackage

// ----- src/sdm_ram.sv -----
module sdm_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/sdm_mac.sv -----
module sdm_mac (
    input  logic               clk,
    input  logic               rst_n,
    input  sdm_pkg::mac_ctl_t  ctl,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [31:0] prod_q,
    output logic signed [31:0] acc_q
);

    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] acc_next;
    logic               prod_vld_reg;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clr)
            acc_next = '0;
        else if (prod_vld_reg)
            acc_next = acc_reg + prod_reg; // wraps modulo 2^64
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctl.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        acc_reg  <= acc_next;
    end

    assign prod_q = sdm_pkg::q_shift_sat(prod_reg);
    assign acc_q  = sdm_pkg::q_shift_sat(acc_reg);

endmodule

// ----- src/sym_diag_matrix_store_matvec.sv -----
// Q16.16 matrix store with y = A x. Holds a MAX_N x MAX_N coefficient matrix and a
// MAX_N vector in block RAM, both cleared by a sweep after reset during which no item
// is taken; configuration writes are taken at any time. Scale and multiply go through
// one shared 32x32 multiply-accumulate unit fed one element per cycle from the single
// read port of the coefficient RAM, so their work is bounded by that port; add uses a
// saturating adder instead. A result can be held off by the consumer. The block takes
// one item at a time and drops ready until every result of that item is in the output
// register. Each result sits in an output register, so the last result can wait for the
// consumer while the next item is already being accepted.
module sym_diag_matrix_store_matvec #(
    parameter int MAX_N = sdm_pkg::SDM_MAX_N
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration write port
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [6:0]         cfg_data,
    // item input
    input  logic               in_valid,
    output logic               in_ready,
    input  sdm_pkg::in_item_t  in_item,
    // result output
    output logic               out_valid,
    input  logic               out_ready,
    output sdm_pkg::out_item_t out_item
);

    localparam int DEPTH = MAX_N * MAX_N;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = (MAX_N > 1) ? $clog2(MAX_N) : 1;

    // configuration registers
    logic       diag_reg;
    logic       sym_reg;
    logic [6:0] size_reg;
    logic [6:0] n_eff;

    // sequencer state
    sdm_pkg::state_t state_reg, state_next;

    // latched item
    logic [5:0]         row_reg, row_next;
    logic [5:0]         col_reg, col_next;
    logic signed [31:0] opnd_reg, opnd_next;
    logic [1:0]         status_reg, status_next;

    // loop counters
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [6:0]    i_reg, i_next;
    logic [6:0]    j_reg, j_next;
    logic [6:0]    jend_reg, jend_next;

    // read pipeline tracking: p1 = RAM data valid, p2 = product valid
    logic          p1_vld_reg, p1_vld_next;
    logic [AW-1:0] p1_addr_reg, p1_addr_next;
    logic          p2_vld_reg;
    logic [AW-1:0] p2_addr_reg;

    // output register
    logic               out_vld_reg, out_vld_next;
    sdm_pkg::out_item_t out_reg, out_next;
    logic               slot_free;

    // memories
    logic          coef_we;
    logic [AW-1:0] coef_waddr;
    logic [31:0]   coef_wdata;
    logic [AW-1:0] coef_raddr;
    logic [31:0]   coef_rdata;
    logic          vec_we;
    logic [IW-1:0] vec_waddr;
    logic [31:0]   vec_wdata;
    logic [IW-1:0] vec_raddr;
    logic [31:0]   vec_rdata;

    // shared multiply-accumulate
    sdm_pkg::mac_ctl_t  mac_ctl;
    logic signed [31:0] mac_b;
    logic signed [31:0] mac_prod;
    logic signed [31:0] mac_acc;

    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;
    logic [AW-1:0] addr_mul;
    logic          in_fire;
    logic          row_bad;
    logic          col_bad;

    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_vld_reg || out_ready;

    // effective size: 0 acts as 1, anything above MAX_N acts as MAX_N
    always_comb
    begin
        if (size_reg == 7'd0)
            n_eff = 7'd1;
        else if (size_reg > 7'(MAX_N))
            n_eff = 7'(MAX_N);
        else
            n_eff = size_reg;
    end

    assign row_bad = {1'b0, in_item.row} >= n_eff;
    assign col_bad = {1'b0, in_item.col} >= n_eff;

    // element (r,c) lives at r*MAX_N + c
    assign addr_a   = AW'(AW'(row_reg[IW-1:0]) * AW'(MAX_N)) + AW'(col_reg[IW-1:0]);
    assign addr_b   = AW'(AW'(col_reg[IW-1:0]) * AW'(MAX_N)) + AW'(row_reg[IW-1:0]);
    assign addr_mul = AW'(AW'(i_reg[IW-1:0]) * AW'(MAX_N)) + AW'(j_reg[IW-1:0]);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diag_reg <= 1'b0;
            sym_reg  <= 1'b0;
            size_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sdm_pkg::CFG_DIAG: diag_reg <= cfg_data[0];
                sdm_pkg::CFG_SYM:  sym_reg  <= cfg_data[0];
                sdm_pkg::CFG_SIZE: size_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer: next state, memory ports and output loading
    always_comb
    begin
        state_next   = state_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        opnd_next    = opnd_reg;
        status_next  = status_reg;
        cnt_next     = cnt_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        jend_next    = jend_reg;
        p1_vld_next  = 1'b0;
        p1_addr_next = p1_addr_reg;
        out_vld_next = out_vld_reg && !out_ready;
        out_next     = out_reg;
        coef_we      = 1'b0;
        coef_waddr   = addr_a;
        coef_wdata   = opnd_reg;
        coef_raddr   = addr_a;
        vec_we       = 1'b0;
        vec_waddr    = row_reg[IW-1:0];
        vec_wdata    = opnd_reg;
        vec_raddr    = j_reg[IW-1:0];
        mac_ctl.vld  = p1_vld_reg;
        mac_ctl.clr  = 1'b0;
        in_ready     = 1'b0;

        unique case (state_reg)
            sdm_pkg::ST_CLR:
            begin
                // zero sweep over both stores after reset
                coef_we    = 1'b1;
                coef_waddr = cnt_reg;
                coef_wdata = '0;
                vec_we     = cnt_reg < AW'(MAX_N);
                vec_waddr  = IW'(cnt_reg);
                vec_wdata  = '0;
                if (cnt_reg == AW'(DEPTH - 1))
                    state_next = sdm_pkg::ST_IDLE;
                else
                    cnt_next = cnt_reg + AW'(1);
            end

            sdm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    row_next    = in_item.row;
                    col_next    = in_item.col;
                    opnd_next   = in_item.operand;
                    status_next = sdm_pkg::STAT_OK;
                    cnt_next    = '0;
                    i_next      = '0;
                    unique case (in_item.kind) inside
                        sdm_pkg::KIND_SET, sdm_pkg::KIND_ADD:
                        begin
                            if (row_bad || col_bad)
                            begin
                                status_next = sdm_pkg::STAT_RANGE;
                                state_next  = sdm_pkg::ST_ACK;
                            end
                            else if (diag_reg && (in_item.row != in_item.col))
                            begin
                                status_next = sdm_pkg::STAT_OFF_DIAG;
                                state_next  = sdm_pkg::ST_ACK;
                            end
                            else if (in_item.kind == sdm_pkg::KIND_SET)
                                state_next = sdm_pkg::ST_SET_A;
                            else
                                state_next = sdm_pkg::ST_ADD_RD_A;
                        end
                        sdm_pkg::KIND_SCALE:
                            state_next = sdm_pkg::ST_SCALE;
                        sdm_pkg::KIND_LOAD:
                        begin
                            if (row_bad)
                            begin
                                status_next = sdm_pkg::STAT_RANGE;
                                state_next  = sdm_pkg::ST_ACK;
                            end
                            else
                                state_next = sdm_pkg::ST_VEC_WR;
                        end
                        sdm_pkg::KIND_MUL:
                            state_next = sdm_pkg::ST_MUL_INIT;
                        default:
                        begin
                            status_next = sdm_pkg::STAT_RANGE;
                            state_next  = sdm_pkg::ST_ACK;
                        end
                    endcase
                end
            end

            sdm_pkg::ST_SET_A:
            begin
                coef_we    = 1'b1;
                coef_waddr = addr_a;
                if (sym_reg && !diag_reg)
                    state_next = sdm_pkg::ST_SET_B;
                else
                    state_next = sdm_pkg::ST_ACK;
            end

            sdm_pkg::ST_SET_B:
            begin
                coef_we    = 1'b1;
                coef_waddr = addr_b;
                state_next = sdm_pkg::ST_ACK;
            end

            sdm_pkg::ST_ADD_RD_A:
            begin
                coef_raddr = addr_a;
                state_next = sdm_pkg::ST_ADD_WR_A;
            end

            sdm_pkg::ST_ADD_WR_A:
            begin
                coef_we    = 1'b1;
                coef_waddr = addr_a;
                coef_wdata = sdm_pkg::sat_add(coef_rdata, opnd_reg);
                // mirror only off the diagonal so a diagonal add lands once
                if (sym_reg && !diag_reg && (row_reg != col_reg))
                    state_next = sdm_pkg::ST_ADD_RD_B;
                else
                    state_next = sdm_pkg::ST_ACK;
            end

            sdm_pkg::ST_ADD_RD_B:
            begin
                coef_raddr = addr_b;
                state_next = sdm_pkg::ST_ADD_WR_B;
            end

            sdm_pkg::ST_ADD_WR_B:
            begin
                coef_we    = 1'b1;
                coef_waddr = addr_b;
                coef_wdata = sdm_pkg::sat_add(coef_rdata, opnd_reg);
                state_next = sdm_pkg::ST_ACK;
            end

            sdm_pkg::ST_VEC_WR:
            begin
                vec_we     = 1'b1;
                vec_waddr  = row_reg[IW-1:0];
                state_next = sdm_pkg::ST_ACK;
            end

            sdm_pkg::ST_SCALE:
            begin
                // read one entry per cycle, write back once it has passed the RAM read and product registers
                coef_raddr   = cnt_reg;
                p1_vld_next  = 1'b1;
                p1_addr_next = cnt_reg;
                coef_we      = p2_vld_reg;
                coef_waddr   = p2_addr_reg;
                coef_wdata   = mac_prod;
                if (cnt_reg == AW'(DEPTH - 1))
                    state_next = sdm_pkg::ST_SCALE_DRAIN;
                else
                    cnt_next = cnt_reg + AW'(1);
            end

            sdm_pkg::ST_SCALE_DRAIN:
            begin
                coef_we    = p2_vld_reg;
                coef_waddr = p2_addr_reg;
                coef_wdata = mac_prod;
                if (!p1_vld_reg && !p2_vld_reg)
                    state_next = sdm_pkg::ST_ACK;
            end

            sdm_pkg::ST_MUL_INIT:
            begin
                mac_ctl.clr = 1'b1;
                if (diag_reg)
                begin
                    j_next    = i_reg;
                    jend_next = i_reg;
                end
                else
                begin
                    j_next    = '0;
                    jend_next = n_eff - 7'd1;
                end
                state_next = sdm_pkg::ST_MUL_ISSUE;
            end

            sdm_pkg::ST_MUL_ISSUE:
            begin
                coef_raddr   = addr_mul;
                vec_raddr    = j_reg[IW-1:0];
                p1_vld_next  = 1'b1;
                p1_addr_next = addr_mul;
                if (j_reg == jend_reg)
                    state_next = sdm_pkg::ST_MUL_DRAIN;
                else
                    j_next = j_reg + 7'd1;
            end

            sdm_pkg::ST_MUL_DRAIN:
            begin
                if (!p1_vld_reg && !p2_vld_reg)
                    state_next = sdm_pkg::ST_MUL_EMIT;
            end

            sdm_pkg::ST_MUL_EMIT:
            begin
                if (slot_free)
                begin
                    out_vld_next          = 1'b1;
                    out_next.status       = sdm_pkg::STAT_OK;
                    out_next.row_index    = 6'(i_reg);
                    out_next.product_value = mac_acc;
                    out_next.last         = (i_reg + 7'd1) == n_eff;
                    if ((i_reg + 7'd1) == n_eff)
                        state_next = sdm_pkg::ST_IDLE;
                    else
                    begin
                        i_next     = i_reg + 7'd1;
                        state_next = sdm_pkg::ST_MUL_INIT;
                    end
                end
            end

            sdm_pkg::ST_ACK:
            begin
                if (slot_free)
                begin
                    out_vld_next           = 1'b1;
                    out_next.status        = status_reg;
                    out_next.row_index     = row_reg;
                    out_next.product_value = '0;
                    out_next.last          = 1'b1;
                    state_next             = sdm_pkg::ST_IDLE;
                end
            end

            default:
                state_next = sdm_pkg::ST_IDLE;
        endcase
    end

    // scale multiplies by the operand, multiply by the vector element
    assign mac_b = (state_reg == sdm_pkg::ST_SCALE || state_reg == sdm_pkg::ST_SCALE_DRAIN)
                   ? opnd_reg : $signed(vec_rdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sdm_pkg::ST_CLR;
            cnt_reg     <= '0;
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            p1_vld_reg  <= p1_vld_next;
            p2_vld_reg  <= p1_vld_reg;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg     <= row_next;
        col_reg     <= col_next;
        opnd_reg    <= opnd_next;
        status_reg  <= status_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        jend_reg    <= jend_next;
        p1_addr_reg <= p1_addr_next;
        p2_addr_reg <= p1_addr_reg;
        out_reg     <= out_next;
    end

    sdm_ram #(
        .DEPTH (DEPTH),
        .WIDTH (32),
        .AW    (AW)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_wdata),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    sdm_ram #(
        .DEPTH (MAX_N),
        .WIDTH (32),
        .AW    (IW)
    ) u_vec_ram (
        .clk   (clk),
        .we    (vec_we),
        .waddr (vec_waddr),
        .wdata (vec_wdata),
        .raddr (vec_raddr),
        .rdata (vec_rdata)
    );

    sdm_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .a      ($signed(coef_rdata)),
        .b      (mac_b),
        .prod_q (mac_prod),
        .acc_q  (mac_acc)
    );

    assign out_valid = out_vld_reg;
    assign out_item  = out_reg;

    // no result can appear while the stores are being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sdm_pkg::ST_CLR |-> !out_vld_reg)
        else $error("result during clear sweep");

    // the multiply unit only sees data while a sweep or a product is running
    assert property (@(posedge clk) disable iff (!rst_n)
        p1_vld_reg |-> (state_reg == sdm_pkg::ST_SCALE || state_reg == sdm_pkg::ST_SCALE_DRAIN
                        || state_reg == sdm_pkg::ST_MUL_ISSUE
                        || state_reg == sdm_pkg::ST_MUL_DRAIN))
        else $error("multiply unit fed outside a sweep");

    // every item but a product row closes with last, and product rows are ok
    assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_reg.last |-> out_reg.status == sdm_pkg::STAT_OK)
        else $error("non-final result with error status");

    // accepting an item never coincides with a store write
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> !coef_we && !vec_we)
        else $error("store written while taking an item");

endmodule
